// ===== src/mrh_pkg.sv =====
// Package for the monotone radix heap: sizes, opcodes, status codes, state and command types.
// No dependencies.
`default_nettype none
package mrh_pkg;
	localparam int NODES    = 256;
	localparam int KEY_BITS = 32;
	localparam int BUCKETS  = 33;
	localparam int ID_W     = $clog2(NODES);
	localparam int BKT_W    = $clog2(BUCKETS);

	typedef logic [ID_W-1:0]     id_t;
	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [BKT_W-1:0]    bkt_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_PEEK   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_DECR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_KEY_LOW  = 2'd2,
		ST_CONFLICT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_LOW, PH_BEST, PH_REBKT
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SCAN_LOW, S_LOW_END, S_LOW_DEC, S_SCAN_BEST, S_BEST_END,
		S_SET_MIN, S_REBKT_RD, S_REBKT_WR, S_TAKE, S_OUT
	} state_t;

	typedef struct packed {
		logic    load_item;
		logic    ptr_clr;
		logic    ptr_inc;
		logic    use_id;
		logic    rd_issue;
		phase_t  phase;
		logic    write_node;
		logic    set_last_min;
		logic    take_min;
		logic    res_load;
		status_t res_status;
	} mrh_cmd_t;

	typedef struct packed {
		op_t  op;
		logic id_present;
		logic key_low;
		logic ptr_last;
		logic low_zero;
		logic heap_nonempty;
	} mrh_sts_t;

	function automatic bkt_t bucket_of(input key_t k, input key_t lm);
		key_t d;
		bkt_t p;
		d = k ^ lm;
		p = '0;
		for (int i = 0; i < KEY_BITS; i++)
			if (d[i]) p = bkt_t'(i + 1);
		if (p > bkt_t'(BUCKETS - 1)) p = bkt_t'(BUCKETS - 1);
		return p;
	endfunction
endpackage
`default_nettype wire

// ===== src/mrh_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface mrh_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mrh_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mrh_ram #(parameter int WIDTH = 8, parameter int DEPTH = 16) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== src/mrh_datapath.sv =====
// Datapath: key and bucket RAMs, presence bits, node count, scan pointer, scan registers,
// result register. Depends on mrh_pkg and mrh_ram.
`default_nettype none
module mrh_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mrh_pkg::mrh_cmd_t cmd,
	output mrh_pkg::mrh_sts_t      sts,
	input  wire logic [1:0]        in_op,
	input  wire logic [7:0]        in_id,
	input  wire logic [31:0]       in_key,
	output logic [7:0]             r_node,
	output logic [31:0]            r_key,
	output logic                   r_empty,
	output logic [1:0]             r_status
);
	import mrh_pkg::*;
	typedef logic [ID_W:0] cnt_t;

	op_t    op_q;
	id_t    id_q, ptr_q, hit_q;
	key_t   key_q, last_min_q, best_q, hit_key_q;
	logic   pres_id_q;
	bkt_t   low_q;
	logic   low_found_q, best_found_q, zero_found_q;
	cnt_t   cnt_q;
	logic [NODES-1:0] present_q;
	logic   rd_vld_s1, pres_s1;
	phase_t phase_s1;
	id_t    ptr_s1;
	logic   key_we, bkt_we;
	logic   low_hit, zero_hit, best_hit, rebkt_hit;
	id_t    addr;
	key_t   key_rd;
	bkt_t   bkt_rd, bkt_wd;

	assign addr   = cmd.use_id ? id_q : ptr_q;
	assign key_we = cmd.write_node;
	assign bkt_we = cmd.write_node | rebkt_hit;
	assign bkt_wd = cmd.write_node ? bucket_of(key_q, last_min_q) : bucket_of(key_rd, last_min_q);

	assign low_hit   = rd_vld_s1 && phase_s1 == PH_LOW && pres_s1 &&
		(!low_found_q || bkt_rd < low_q);
	assign zero_hit  = rd_vld_s1 && phase_s1 == PH_LOW && pres_s1 &&
		bkt_rd == '0 && !zero_found_q;
	assign best_hit  = rd_vld_s1 && phase_s1 == PH_BEST && pres_s1 && bkt_rd == low_q &&
		(!best_found_q || key_rd < best_q);
	assign rebkt_hit = rd_vld_s1 && phase_s1 == PH_REBKT && pres_s1 && bkt_rd == low_q;

	mrh_ram #(.WIDTH(KEY_BITS), .DEPTH(NODES)) u_key (
		.clk(clk), .we(key_we), .addr(addr), .wdata(key_q), .rdata(key_rd));
	mrh_ram #(.WIDTH(BKT_W), .DEPTH(NODES)) u_bkt (
		.clk(clk), .we(bkt_we), .addr(addr), .wdata(bkt_wd), .rdata(bkt_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			last_min_q   <= '0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			low_found_q  <= 1'b0;
			best_found_q <= 1'b0;
			zero_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_issue;
			if (cmd.ptr_clr) ptr_q <= '0;
			else if (cmd.ptr_inc) ptr_q <= ptr_q + 1'b1;
			if (cmd.load_item) begin
				low_found_q  <= 1'b0;
				best_found_q <= 1'b0;
				zero_found_q <= 1'b0;
			end
			if (low_hit) low_found_q <= 1'b1;
			if (zero_hit) zero_found_q <= 1'b1;
			if (best_hit) best_found_q <= 1'b1;
			if (cmd.set_last_min) last_min_q <= best_q;
			if (cmd.write_node) begin
				present_q[id_q] <= 1'b1;
				if (op_q == OP_INSERT) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.take_min && op_q == OP_REMOVE) begin
				present_q[hit_q] <= 1'b0;
				cnt_q            <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pres_s1  <= present_q[addr];
		ptr_s1   <= addr;
		phase_s1 <= cmd.phase;
		if (cmd.load_item) begin
			op_q      <= op_t'(in_op);
			id_q      <= id_t'(in_id);
			key_q     <= key_t'(in_key);
			pres_id_q <= present_q[in_id];
		end
		if (low_hit) low_q <= bkt_rd;
		if (zero_hit) begin
			hit_q     <= ptr_s1;
			hit_key_q <= key_rd;
		end
		if (best_hit) begin
			best_q    <= key_rd;
			hit_q     <= ptr_s1;
			hit_key_q <= key_rd;
		end
		if (cmd.res_load) begin
			r_status <= cmd.res_status;
			r_node   <= cmd.take_min ? hit_q : '0;
			r_key    <= cmd.take_min ? hit_key_q : '0;
		end
	end

	assign r_empty = (cnt_q == '0);

	always_comb begin
		sts.op            = op_q;
		sts.id_present    = pres_id_q;
		sts.key_low       = key_q < last_min_q;
		sts.ptr_last      = ptr_q == id_t'(NODES - 1);
		sts.low_zero      = low_q == '0;
		sts.heap_nonempty = cnt_q != '0;
	end
endmodule
`default_nettype wire

// ===== src/mrh_ctrl.sv =====
// Controller state machine sequencing checks, scans and the re-bucket pass over the node RAMs.
// Depends on mrh_pkg.
`default_nettype none
module mrh_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire mrh_pkg::mrh_sts_t sts,
	output mrh_pkg::mrh_cmd_t      cmd
);
	import mrh_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.phase      = PH_LOW;
		cmd.res_status = ST_OK;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.op == OP_INSERT || sts.op == OP_DECR) begin
					cmd.res_load = 1'b1;
					state_d      = S_OUT;
					if ((sts.op == OP_INSERT && sts.id_present) ||
						(sts.op == OP_DECR && !sts.id_present))
						cmd.res_status = ST_CONFLICT;
					else if (sts.key_low)
						cmd.res_status = ST_KEY_LOW;
					else begin
						cmd.use_id     = 1'b1;
						cmd.write_node = 1'b1;
					end
				end else if (!sts.heap_nonempty) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_EMPTY;
					state_d        = S_OUT;
				end else begin
					cmd.ptr_clr = 1'b1;
					state_d     = S_SCAN_LOW;
				end
			end
			S_SCAN_LOW: begin
				cmd.rd_issue = 1'b1;
				cmd.phase    = PH_LOW;
				cmd.ptr_inc  = 1'b1;
				if (sts.ptr_last) state_d = S_LOW_END;
			end
			S_LOW_END: state_d = S_LOW_DEC;
			S_LOW_DEC: begin
				if (sts.low_zero) state_d = S_TAKE;
				else begin
					cmd.ptr_clr = 1'b1;
					state_d     = S_SCAN_BEST;
				end
			end
			S_SCAN_BEST: begin
				cmd.rd_issue = 1'b1;
				cmd.phase    = PH_BEST;
				cmd.ptr_inc  = 1'b1;
				if (sts.ptr_last) state_d = S_BEST_END;
			end
			S_BEST_END: state_d = S_SET_MIN;
			S_SET_MIN: begin
				cmd.set_last_min = 1'b1;
				cmd.ptr_clr      = 1'b1;
				state_d          = S_REBKT_RD;
			end
			S_REBKT_RD: begin
				cmd.rd_issue = 1'b1;
				cmd.phase    = PH_REBKT;
				state_d      = S_REBKT_WR;
			end
			S_REBKT_WR: begin
				if (sts.ptr_last) state_d = S_TAKE;
				else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_REBKT_RD;
				end
			end
			S_TAKE: begin
				cmd.take_min   = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/monotone_radix_heap_top.sv =====
// Monotone radix heap priority queue: top level joining controller and datapath.
// Depends on mrh_pkg, mrh_if, mrh_ctrl, mrh_datapath.
// One transaction at a time: the input is ready only while the block is idle, and the
// result holds on the output until taken; the next transaction is accepted at the edge
// after the one that takes the result. Insert and decrease-key check and write the node,
// then offer their result. Peek and remove first scan every node to find the lowest
// non-empty bucket; when that is bucket 0 the result is taken from that scan.
// Otherwise a second scan finds the smallest key of that bucket and a read-then-write pass
// over every node re-buckets it. This pass reads and then writes each node in turn, as the
// key and bucket RAMs have a single port.
`default_nettype none
module monotone_radix_heap_top (
	input wire logic clk,
	input wire logic arst_n,
	mrh_if.sink      in_ch,
	mrh_if.source    out_ch
);
	import mrh_pkg::*;
	mrh_cmd_t cmd;
	mrh_sts_t sts;
	logic [7:0] r_node; logic [31:0] r_key; logic r_empty; logic [1:0] r_status;

	mrh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd));
	mrh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_op(in_ch.data[41:40]), .in_id(in_ch.data[39:32]), .in_key(in_ch.data[31:0]),
		.r_node(r_node), .r_key(r_key), .r_empty(r_empty), .r_status(r_status));

	assign out_ch.data = {r_node, r_key, r_empty, r_status};
endmodule
`default_nettype wire

// ===== src/mrh_checker.sv =====
// Port-level checker for the radix heap top level, bound to it.
// Depends only on the top level's ports.
`default_nettype none
module mrh_checker (
	input wire logic clk, input wire logic arst_n,
	input wire logic iv, input wire logic ir, input wire logic ov, input wire logic orr,
	input wire logic [42:0] od
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n) ov && !orr |=> ov)
		else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !orr |=> $stable(od)) else $error("result changed while waiting");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(ir && ov))
		else $error("accept while result pending");
	a_errz: assert property (@(posedge clk) disable iff (!arst_n)
		ov && od[1:0] != 2'd0 |-> od[42:3] == 40'd0) else $error("error result nonzero");
endmodule
bind monotone_radix_heap_top mrh_checker u_chk (.clk(clk), .arst_n(arst_n),
	.iv(in_ch.valid), .ir(in_ch.ready), .ov(out_ch.valid), .orr(out_ch.ready),
	.od(out_ch.data));
`default_nettype wire

// ===== tb/sv/monotone_radix_heap_top_test.sv =====
// Testbench for monotone_radix_heap_top: directed and random insert, peek, remove and
// decrease-key transactions, checked against an in-bench radix heap predictor.
// Depends on mrh_pkg, mrh_if and the monotone_radix_heap_top RTL.
`timescale 1ns / 100ps
`default_nettype none
module monotone_radix_heap_top_test;
	import mrh_pkg::*;

	localparam int IN_W  = 2 + 8 + KEY_BITS;
	localparam int OUT_W = 8 + KEY_BITS + 1 + 2;

	typedef struct {
		logic [7:0] node;
		key_t       key;
		logic       empty;
		status_t    status;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mrh_if #(.W(IN_W))  in_ch();
	mrh_if #(.W(OUT_W)) out_ch();

	monotone_radix_heap_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #2 clk = ~clk;

	key_t         shadow_key [NODES];
	int           shadow_bkt [NODES];
	bit           shadow_present [NODES];
	key_t         shadow_last_min;
	int           shadow_count;
	heap_result_t pending_results [$];
	int           mismatches;
	int           burst_left;

	function automatic int bucket_for(key_t k);
		key_t d;
		int   p;
		d = k ^ shadow_last_min;
		p = 0;
		for (int i = 0; i < KEY_BITS; i++)
			if (d[i]) p = i + 1;
		if (p > BUCKETS - 1) p = BUCKETS - 1;
		return p;
	endfunction

	function automatic heap_result_t predict_heap_op(op_t op, logic [7:0] id, key_t k);
		heap_result_t r;
		int           low;
		key_t         best;
		r.node = '0;
		r.key = '0;
		r.status = ST_OK;
		if (op == OP_INSERT || op == OP_DECR) begin
			if ((op == OP_INSERT && shadow_present[id]) || (op == OP_DECR && !shadow_present[id]))
				r.status = ST_CONFLICT;
			else if (k < shadow_last_min)
				r.status = ST_KEY_LOW;
			else begin
				if (!shadow_present[id]) shadow_count++;
				shadow_key[id] = k;
				shadow_bkt[id] = bucket_for(k);
				shadow_present[id] = 1'b1;
			end
		end else begin
			low = 1000;
			for (int i = 0; i < NODES; i++)
				if (shadow_present[i] && shadow_bkt[i] < low) low = shadow_bkt[i];
			if (low == 1000)
				r.status = ST_EMPTY;
			else begin
				if (low > 0) begin
					best = '1;
					for (int i = 0; i < NODES; i++)
						if (shadow_present[i] && shadow_bkt[i] == low && shadow_key[i] < best)
							best = shadow_key[i];
					shadow_last_min = best;
					for (int i = 0; i < NODES; i++)
						if (shadow_present[i] && shadow_bkt[i] == low)
							shadow_bkt[i] = bucket_for(shadow_key[i]);
				end
				for (int i = 0; i < NODES; i++)
					if (shadow_present[i] && shadow_bkt[i] == 0) begin
						r.node = i[7:0];
						r.key = shadow_key[i];
						if (op == OP_REMOVE) begin
							shadow_present[i] = 1'b0;
							shadow_count--;
						end
						break;
					end
			end
		end
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	task automatic send_op(op_t op, logic [7:0] id, key_t k);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data <= {op, id, k};
		do @(posedge clk); while (!in_ch.ready);
		pending_results = {pending_results, predict_heap_op(op, id, k)};
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		heap_result_t exp_r;
		logic [OUT_W-1:0] got;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== {exp_r.node, exp_r.key, exp_r.empty, exp_r.status}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp node %0d key %h empty %b status %0d, got %h",
							exp_r.node, exp_r.key, exp_r.empty, exp_r.status, got);
				end
			end
		end
	end

	// receiver stall pattern: rotates through always ready, random ready and one-in-eight ready as rx_cycle >> 8 advances
	int rx_cycle = 0;
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle >> 8) % 3)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			default: out_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic test_empty_heap();
		send_op(OP_PEEK, 8'h00, '0);
		send_op(OP_REMOVE, 8'hFF, '1);
		send_op(OP_DECR, 8'h03, 32'd5);
	endtask

	task automatic test_conflicts_and_key_order();
		send_op(OP_INSERT, 8'h00, 32'h0);
		send_op(OP_INSERT, 8'h00, 32'h7);
		send_op(OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
		send_op(OP_INSERT, 8'h05, 32'd100);
		send_op(OP_INSERT, 8'h06, 32'd100);
		send_op(OP_PEEK, 8'h00, '0);
		send_op(OP_REMOVE, 8'h00, '0);
		send_op(OP_REMOVE, 8'h00, '0);
		send_op(OP_INSERT, 8'h09, 32'd50);
		send_op(OP_DECR, 8'hFF, 32'd50);
		send_op(OP_DECR, 8'h0A, 32'd1);
	endtask

	task automatic test_ties_and_decrease();
		send_op(OP_DECR, 8'hFF, 32'd200);
		send_op(OP_DECR, 8'h06, 32'h8000_0000);
		send_op(OP_INSERT, 8'h80, 32'd100);
		send_op(OP_PEEK, 8'h00, '0);
		send_op(OP_REMOVE, 8'h00, '0);
		send_op(OP_REMOVE, 8'h00, '0);
		send_op(OP_REMOVE, 8'h00, '0);
		send_op(OP_REMOVE, 8'h00, '0);
		send_op(OP_REMOVE, 8'h00, '0);
		send_op(OP_PEEK, 8'h00, '0);
	endtask

	function automatic key_t key_at_or_above_min();
		key_t off;
		key_t k;
		int   w;
		w = $urandom_range(0, KEY_BITS);
		off = (w == KEY_BITS) ? key_t'({$urandom, $urandom}) : (key_t'($urandom) & ((key_t'(1) << w) - 1));
		k = shadow_last_min + off;
		if (k < shadow_last_min) k = '1;
		return k;
	endfunction

	task automatic test_random_ops();
		int         sel;
		logic [7:0] id;
		for (int n = 0; n < 400; n++) begin
			if (n == 200) drain_results();
			sel = $urandom_range(0, 99);
			id = 8'($urandom);
			if (sel < 10) begin
				send_op(op_t'($urandom_range(0, 3)), id, key_t'($urandom));
			end else if (sel < 45 && shadow_count < 40) begin
				for (int t = 0; t < 8 && shadow_present[id]; t++) id = 8'($urandom);
				send_op(OP_INSERT, id, key_at_or_above_min());
			end else if (sel < 60 && shadow_count > 0) begin
				for (int t = 0; t < 64 && !shadow_present[id]; t++) id = 8'($urandom);
				send_op(OP_DECR, id, ($urandom_range(0, 3) == 0) ? key_t'($urandom)
					: key_at_or_above_min());
			end else if (sel < 70) begin
				send_op(OP_PEEK, id, key_t'($urandom));
			end else begin
				send_op(OP_REMOVE, id, key_t'($urandom));
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		mismatches = 0;
		burst_left = 0;
		shadow_last_min = '0;
		shadow_count = 0;
		for (int i = 0; i < NODES; i++) shadow_present[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_heap();
		test_conflicts_and_key_order();
		test_ties_and_decrease();
		test_random_ops();
		drain_results();
		repeat (3 * NODES + 50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
